// ----- rtl/i2cbr_pkg.sv -----
package i2cbr_pkg;

   // Width of the tick counter that times every line level.
   localparam int WAIT_WIDTH_DEFAULT = 16;

   // Width of the timing registers as written through the register port.
   localparam int TICKS_WIDTH = 16;
   localparam int PULSES_WIDTH = 5;
   localparam int REPEATS_WIDTH = 3;
   localparam int CSR_INDEX_WIDTH = 2;

   // Highest number of SCL pulses that a run may try.
   localparam logic [PULSES_WIDTH-1:0] MAX_PULSE_LIMIT = 5'd16;

   // Register reset values.
   localparam logic [TICKS_WIDTH-1:0]   ABORT_TICKS_RESET   = 16'd50;
   localparam logic [TICKS_WIDTH-1:0]   HALF_TICKS_RESET    = 16'd50;
   localparam logic [PULSES_WIDTH-1:0]  MAX_PULSES_RESET    = 5'd16;
   localparam logic [REPEATS_WIDTH-1:0] START_REPEATS_RESET = 3'd5;

   // Register indexes on the register port.
   typedef enum logic [CSR_INDEX_WIDTH-1:0] {
      CSR_ABORT_TICKS   = 2'd0,
      CSR_HALF_TICKS    = 2'd1,
      CSR_MAX_PULSES    = 2'd2,
      CSR_START_REPEATS = 2'd3
   } csr_index_type;

   typedef enum logic [3:0] {
      PH_IDLE       = 4'd0,
      PH_PULSE_LOW  = 4'd1,
      PH_PULSE_HIGH = 4'd2,
      PH_ST_SDA_HI  = 4'd3,
      PH_ST_SCL_HI  = 4'd4,
      PH_ST_SDA_LO  = 4'd5,
      PH_ST_SCL_LO  = 4'd6,
      PH_STOP_A     = 4'd7,
      PH_STOP_B     = 4'd8
   } phase_type;

   // One result word, highest bit first.
   typedef struct packed {
      logic [2:0] pad;
      logic       failed;
      logic       done_res;
      logic       busy_res;
      logic       sda_release;
      logic       scl_release;
   } rsp_word_type;

endpackage

// ----- rtl/i2c_bus_recovery_sequencer.sv -----
// I2C bus clear sequencer, one input word per clock tick of the timing base.
// The result word for an input word is registered and appears in the cycle after it is accepted.
// Throughput: one word per cycle; an input word is taken while the output register is
// empty or being emptied in the same cycle, so the sequencer state advances once per word.
// Reset (synchronous, active high): sequencer idle with both lines released, the
// registers back to their defaults, and the output register empty.
module i2c_bus_recovery_sequencer #(
   parameter int WAIT_WIDTH = i2cbr_pkg::WAIT_WIDTH_DEFAULT
) (
   input  logic       clock,
   input  logic       reset,

   // Input channel, one word per tick.
   input  logic       req_tvalid,
   output logic       req_tready,
   input  logic [7:0] req_tdata,   // [0] go, [1] sda_level, [2] scl_level, [7:3] zero

   // Result channel, one word for every input word.
   output logic       rsp_tvalid,
   input  logic       rsp_tready,
   output logic [7:0] rsp_tdata,   // [0] scl_release, [1] sda_release, [2] busy_res,
                                   // [3] done_res, [4] failed, [7:5] zero

   // Register write port.
   input  logic                                   csr_valid,
   output logic                                   csr_ready,
   input  logic [i2cbr_pkg::CSR_INDEX_WIDTH-1:0]  csr_index,
   input  logic [31:0]                            csr_data
);

   localparam int TW = i2cbr_pkg::TICKS_WIDTH;
   localparam int PW = i2cbr_pkg::PULSES_WIDTH;
   localparam int RW = i2cbr_pkg::REPEATS_WIDTH;

   // Configuration registers.
   logic [TW-1:0] abort_ticks_ff;
   logic [TW-1:0] half_ticks_ff;
   logic [PW-1:0] max_pulses_ff;
   logic [RW-1:0] start_repeats_ff;

   // Sequencer state and its next values.
   i2cbr_pkg::phase_type phase_ff, phase_in;
   logic [WAIT_WIDTH-1:0] wait_ff, wait_in;
   logic [PW-1:0] pulse_ff, pulse_in;
   logic [RW-1:0] start_ff, start_in;
   logic scl_drive_ff, scl_drive_in;
   logic sda_drive_ff, sda_drive_in;
   logic fail_ff, fail_in;
   logic done_in;

   // Output register.
   logic rsp_valid_ff;
   i2cbr_pkg::rsp_word_type rsp_word_ff, rsp_word_in;

   logic req_accept;
   logic go, sda_in, scl_in;
   logic expired;
   logic [WAIT_WIDTH-1:0] abort_len, half_len;
   logic [PW-1:0] pulse_limit;
   logic [PW-1:0] pulse_inc;
   logic [RW-1:0] start_inc;

   // The register port never stalls.
   assign csr_ready = 1'b1;

   always_ff @(posedge clock) begin
      if (reset) begin
         abort_ticks_ff   <= i2cbr_pkg::ABORT_TICKS_RESET;
         half_ticks_ff    <= i2cbr_pkg::HALF_TICKS_RESET;
         max_pulses_ff    <= i2cbr_pkg::MAX_PULSES_RESET;
         start_repeats_ff <= i2cbr_pkg::START_REPEATS_RESET;
      end else if (csr_valid) begin
         unique case (i2cbr_pkg::csr_index_type'(csr_index))
            i2cbr_pkg::CSR_ABORT_TICKS:   abort_ticks_ff   <= csr_data[TW-1:0];
            i2cbr_pkg::CSR_HALF_TICKS:    half_ticks_ff    <= csr_data[TW-1:0];
            i2cbr_pkg::CSR_MAX_PULSES:    max_pulses_ff    <= csr_data[PW-1:0];
            i2cbr_pkg::CSR_START_REPEATS: start_repeats_ff <= csr_data[RW-1:0];
            default: begin
            end
         endcase
      end
   end

   // Wait lengths: a zero length acts as one tick, and a length beyond the
   // counter range saturates at the counter's largest value.
   generate
      if (WAIT_WIDTH >= TW) begin : g_wide_wait
         always_comb begin
            abort_len = WAIT_WIDTH'(abort_ticks_ff);
            half_len  = WAIT_WIDTH'(half_ticks_ff);
            if (abort_ticks_ff == '0) abort_len = WAIT_WIDTH'(1);
            if (half_ticks_ff == '0) half_len = WAIT_WIDTH'(1);
         end
      end else begin : g_narrow_wait
         always_comb begin
            abort_len = abort_ticks_ff[WAIT_WIDTH-1:0];
            half_len  = half_ticks_ff[WAIT_WIDTH-1:0];
            if (abort_ticks_ff[TW-1:WAIT_WIDTH] != '0) abort_len = '1;
            else if (abort_ticks_ff == '0) abort_len = WAIT_WIDTH'(1);
            if (half_ticks_ff[TW-1:WAIT_WIDTH] != '0) half_len = '1;
            else if (half_ticks_ff == '0) half_len = WAIT_WIDTH'(1);
         end
      end
   endgenerate

   // Pulse limit clamped to the range one to sixteen.
   always_comb begin
      if (max_pulses_ff == '0) pulse_limit = PW'(1);
      else if (max_pulses_ff > i2cbr_pkg::MAX_PULSE_LIMIT)
         pulse_limit = i2cbr_pkg::MAX_PULSE_LIMIT;
      else pulse_limit = max_pulses_ff;
   end

   // A new word is taken whenever the output register has room this cycle.
   assign req_accept = req_tvalid && req_tready;
   assign req_tready = !rsp_valid_ff || rsp_tready;

   assign go     = req_tdata[0];
   assign sda_in = req_tdata[1];
   assign scl_in = req_tdata[2];

   assign pulse_inc = pulse_ff + PW'(1);
   assign start_inc = start_ff + RW'(1);

   // Next state for one tick.
   always_comb begin
      phase_in     = phase_ff;
      wait_in      = wait_ff;
      pulse_in     = pulse_ff;
      start_in     = start_ff;
      scl_drive_in = scl_drive_ff;
      sda_drive_in = sda_drive_ff;
      fail_in      = fail_ff;
      done_in      = 1'b0;
      expired      = 1'b0;

      // The wait counter runs on every tick of a run and expires at one.
      if (phase_ff != i2cbr_pkg::PH_IDLE) begin
         if (wait_ff > WAIT_WIDTH'(1)) begin
            wait_in = wait_ff - WAIT_WIDTH'(1);
         end else begin
            wait_in = '0;
            expired = 1'b1;
         end
      end

      if (phase_ff == i2cbr_pkg::PH_IDLE) begin
         if (go) begin
            pulse_in = '0;
            start_in = '0;
            if (!sda_in) begin
               // SDA held low by a device: start clocking it free.
               fail_in      = 1'b1;
               scl_drive_in = 1'b0;
               phase_in     = i2cbr_pkg::PH_PULSE_LOW;
               wait_in      = abort_len;
            end else begin
               fail_in = 1'b0;
               if (start_repeats_ff != '0) begin
                  sda_drive_in = 1'b1;
                  phase_in     = i2cbr_pkg::PH_ST_SDA_HI;
                  wait_in      = half_len;
               end else begin
                  phase_in = i2cbr_pkg::PH_STOP_A;
                  wait_in  = abort_len;
               end
            end
         end
      end else if (expired) begin
         unique case (phase_ff)
            i2cbr_pkg::PH_PULSE_LOW: begin
               scl_drive_in = 1'b1;
               phase_in     = i2cbr_pkg::PH_PULSE_HIGH;
               wait_in      = abort_len;
            end
            i2cbr_pkg::PH_PULSE_HIGH: begin
               // End of a pulse: the bus is free once both lines read high.
               pulse_in = pulse_inc;
               if (scl_in && sda_in) begin
                  fail_in  = 1'b0;
                  start_in = '0;
                  if (start_repeats_ff != '0) begin
                     sda_drive_in = 1'b1;
                     phase_in     = i2cbr_pkg::PH_ST_SDA_HI;
                     wait_in      = half_len;
                  end else begin
                     phase_in = i2cbr_pkg::PH_STOP_A;
                     wait_in  = abort_len;
                  end
               end else if (pulse_inc >= pulse_limit) begin
                  phase_in = i2cbr_pkg::PH_STOP_A;
                  wait_in  = abort_len;
               end else begin
                  scl_drive_in = 1'b0;
                  phase_in     = i2cbr_pkg::PH_PULSE_LOW;
                  wait_in      = abort_len;
               end
            end
            i2cbr_pkg::PH_ST_SDA_HI: begin
               scl_drive_in = 1'b1;
               phase_in     = i2cbr_pkg::PH_ST_SCL_HI;
               wait_in      = half_len;
            end
            i2cbr_pkg::PH_ST_SCL_HI: begin
               sda_drive_in = 1'b0;
               phase_in     = i2cbr_pkg::PH_ST_SDA_LO;
               wait_in      = half_len;
            end
            i2cbr_pkg::PH_ST_SDA_LO: begin
               scl_drive_in = 1'b0;
               phase_in     = i2cbr_pkg::PH_ST_SCL_LO;
               wait_in      = half_len;
            end
            i2cbr_pkg::PH_ST_SCL_LO: begin
               start_in = start_inc;
               if (start_inc < start_repeats_ff) begin
                  sda_drive_in = 1'b1;
                  phase_in     = i2cbr_pkg::PH_ST_SDA_HI;
                  wait_in      = half_len;
               end else begin
                  phase_in = i2cbr_pkg::PH_STOP_A;
                  wait_in  = abort_len;
               end
            end
            i2cbr_pkg::PH_STOP_A: begin
               scl_drive_in = 1'b1;
               phase_in     = i2cbr_pkg::PH_STOP_B;
               wait_in      = abort_len;
            end
            i2cbr_pkg::PH_STOP_B: begin
               // SDA rising while SCL is high closes the run with a stop.
               sda_drive_in = 1'b1;
               phase_in     = i2cbr_pkg::PH_IDLE;
               wait_in      = '0;
               done_in      = 1'b1;
            end
            default: begin
               phase_in = i2cbr_pkg::PH_IDLE;
               wait_in  = '0;
            end
         endcase
      end
   end

   // Result word built from the state after this tick.
   always_comb begin
      rsp_word_in             = '0;
      rsp_word_in.scl_release = scl_drive_in;
      rsp_word_in.sda_release = sda_drive_in;
      rsp_word_in.busy_res    = (phase_in != i2cbr_pkg::PH_IDLE);
      rsp_word_in.done_res    = done_in;
      rsp_word_in.failed      = done_in && fail_in;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         phase_ff     <= i2cbr_pkg::PH_IDLE;
         wait_ff      <= '0;
         pulse_ff     <= '0;
         start_ff     <= '0;
         scl_drive_ff <= 1'b1;
         sda_drive_ff <= 1'b1;
         fail_ff      <= 1'b0;
      end else if (req_accept) begin
         phase_ff     <= phase_in;
         wait_ff      <= wait_in;
         pulse_ff     <= pulse_in;
         start_ff     <= start_in;
         scl_drive_ff <= scl_drive_in;
         sda_drive_ff <= sda_drive_in;
         fail_ff      <= fail_in;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (req_accept) begin
         rsp_valid_ff <= 1'b1;
      end else if (rsp_tready) begin
         rsp_valid_ff <= 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (req_accept) begin
         rsp_word_ff <= rsp_word_in;
      end
   end

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = rsp_word_ff;

endmodule

// ----- test/i2c_bus_recovery_sequencer_test.sv -----
`timescale 1ns / 100ps

module i2c_bus_recovery_sequencer_test;

   // Field widths taken from the package.
   localparam int TICKS_WIDTH = i2cbr_pkg::TICKS_WIDTH;
   localparam int PULSES_WIDTH = i2cbr_pkg::PULSES_WIDTH;
   localparam int REPEATS_WIDTH = i2cbr_pkg::REPEATS_WIDTH;
   localparam int CSR_INDEX_WIDTH = i2cbr_pkg::CSR_INDEX_WIDTH;
   localparam int WAIT_WIDTH_DEFAULT = i2cbr_pkg::WAIT_WIDTH_DEFAULT;

   // Each side holds off in about this many cycles out of a hundred.
   localparam int unsigned IDLE_PCT = 17;
   // Window of cycles in which neither side holds off at all.
   localparam int unsigned STEADY_FROM = 800;
   localparam int unsigned STEADY_TO = 1600;
   // Cycles allowed after the last word returns before a register write or the end.
   localparam int unsigned SETTLE_CYCLES = 4;
   // Cycles without any handshake before the run is declared hung.
   localparam int unsigned WATCHDOG_LIMIT = 2000;
   localparam int unsigned REPORT_LIMIT = 10;
   localparam int PHASES = 10;
   localparam int BURSTS = 6;
   localparam int BURST_WORDS = 23;
   // Hold length of the closing run, long against the random phases.
   localparam int LONG_HOLD = 50;

   typedef enum logic [1:0] {
      STIM_TICK,
      STIM_CSR,
      STIM_DRAIN
   } stim_kind_type;

   typedef struct {
      stim_kind_type            kind;
      logic                     go;
      logic                     sda;
      logic                     scl;
      i2cbr_pkg::csr_index_type index;
      logic [31:0]              data;
   } stim_type;

   logic        clock = 1'b0;
   logic        reset = 1'b1;

   logic        req_tvalid = 1'b0;
   logic        req_tready;
   logic [7:0]  req_tdata = '0;   // [0] go, [1] sda_level, [2] scl_level, [7:3] zero

   logic        rsp_tvalid;
   logic        rsp_tready = 1'b0;
   logic [7:0]  rsp_tdata;        // [0] scl_release, [1] sda_release, [2] busy_res,
                                  // [3] done_res, [4] failed, [7:5] zero

   logic                       csr_valid = 1'b0;
   logic                       csr_ready;
   logic [CSR_INDEX_WIDTH-1:0] csr_index = i2cbr_pkg::CSR_ABORT_TICKS;
   logic [31:0]                csr_data = '0;

   i2c_bus_recovery_sequencer dut (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .csr_valid  (csr_valid),
      .csr_ready  (csr_ready),
      .csr_index  (csr_index),
      .csr_data   (csr_data)
   );

   always begin
      #10 clock = 1'b1;
      #10 clock = 1'b0;
   end

   // ---------------------------------------------------------------------------------
   // Sequencer prediction. This is an independent copy of the bus-clear state machine,
   // stepped once for every input word the block accepts.
   // ---------------------------------------------------------------------------------

   // Register copies, updated when a register write is accepted.
   logic [TICKS_WIDTH-1:0]   cfg_abort_len;
   logic [TICKS_WIDTH-1:0]   cfg_half_len;
   logic [PULSES_WIDTH-1:0]  cfg_pulse_max;
   logic [REPEATS_WIDTH-1:0] cfg_start_reps;

   // Sequencer state.
   i2cbr_pkg::phase_type            seq_phase;
   logic [WAIT_WIDTH_DEFAULT-1:0]   hold_left;
   logic [PULSES_WIDTH-1:0]         pulses_sent;
   logic [REPEATS_WIDTH-1:0]        starts_sent;
   logic                            scl_out;
   logic                            sda_out;
   logic                            bus_stuck;

   // A hold of zero ticks behaves as one tick. The counter is as wide as the
   // register, so no length ever has to be clipped.
   function automatic logic [WAIT_WIDTH_DEFAULT-1:0] hold_of(logic [TICKS_WIDTH-1:0] n);
      return (n == '0) ? WAIT_WIDTH_DEFAULT'(1) : WAIT_WIDTH_DEFAULT'(n);
   endfunction

   // The pulse limit is pulled into the range one to sixteen.
   function automatic logic [PULSES_WIDTH-1:0] pulse_cap();
      if (cfg_pulse_max == '0)
         return PULSES_WIDTH'(1);
      return (cfg_pulse_max > i2cbr_pkg::MAX_PULSE_LIMIT) ? i2cbr_pkg::MAX_PULSE_LIMIT
                                                          : cfg_pulse_max;
   endfunction

   function automatic void enter_stop();
      seq_phase = i2cbr_pkg::PH_STOP_A;
      hold_left = hold_of(cfg_abort_len);
   endfunction

   function automatic void enter_start();
      sda_out = 1'b1;
      seq_phase = i2cbr_pkg::PH_ST_SDA_HI;
      hold_left = hold_of(cfg_half_len);
   endfunction

   function automatic void enter_pulse();
      scl_out = 1'b0;
      seq_phase = i2cbr_pkg::PH_PULSE_LOW;
      hold_left = hold_of(cfg_abort_len);
   endfunction

   // The bus is free: send the start sequences, or go straight to the stop.
   function automatic void bus_freed();
      bus_stuck = 1'b0;
      starts_sent = '0;
      if (cfg_start_reps != '0)
         enter_start();
      else
         enter_stop();
   endfunction

   // Advances the sequencer by one tick and returns the word it should report.
   function automatic i2cbr_pkg::rsp_word_type bus_clear_tick(logic go, logic sda,
                                                               logic scl);
      i2cbr_pkg::rsp_word_type word;
      logic expired;
      logic finished;
      expired = 1'b0;
      finished = 1'b0;
      if (seq_phase != i2cbr_pkg::PH_IDLE) begin
         if (hold_left > 1) begin
            hold_left = hold_left - 1'b1;
         end else begin
            hold_left = '0;
            expired = 1'b1;
         end
      end
      if (seq_phase == i2cbr_pkg::PH_IDLE) begin
         if (go) begin
            pulses_sent = '0;
            starts_sent = '0;
            if (!sda) begin
               bus_stuck = 1'b1;
               enter_pulse();
            end else begin
               bus_freed();
            end
         end
      end else if (expired) begin
         case (seq_phase)
            i2cbr_pkg::PH_PULSE_LOW: begin
               scl_out = 1'b1;
               seq_phase = i2cbr_pkg::PH_PULSE_HIGH;
               hold_left = hold_of(cfg_abort_len);
            end
            i2cbr_pkg::PH_PULSE_HIGH: begin
               // Both lines are sampled on the tick the released half of a pulse ends.
               pulses_sent = pulses_sent + 1'b1;
               if (scl && sda)
                  bus_freed();
               else if (pulses_sent >= pulse_cap())
                  enter_stop();
               else
                  enter_pulse();
            end
            i2cbr_pkg::PH_ST_SDA_HI: begin
               scl_out = 1'b1;
               seq_phase = i2cbr_pkg::PH_ST_SCL_HI;
               hold_left = hold_of(cfg_half_len);
            end
            i2cbr_pkg::PH_ST_SCL_HI: begin
               sda_out = 1'b0;
               seq_phase = i2cbr_pkg::PH_ST_SDA_LO;
               hold_left = hold_of(cfg_half_len);
            end
            i2cbr_pkg::PH_ST_SDA_LO: begin
               scl_out = 1'b0;
               seq_phase = i2cbr_pkg::PH_ST_SCL_LO;
               hold_left = hold_of(cfg_half_len);
            end
            i2cbr_pkg::PH_ST_SCL_LO: begin
               starts_sent = starts_sent + 1'b1;
               if (starts_sent < cfg_start_reps)
                  enter_start();
               else
                  enter_stop();
            end
            i2cbr_pkg::PH_STOP_A: begin
               scl_out = 1'b1;
               seq_phase = i2cbr_pkg::PH_STOP_B;
               hold_left = hold_of(cfg_abort_len);
            end
            i2cbr_pkg::PH_STOP_B: begin
               sda_out = 1'b1;
               seq_phase = i2cbr_pkg::PH_IDLE;
               hold_left = '0;
               finished = 1'b1;
            end
            default: begin
               seq_phase = i2cbr_pkg::PH_IDLE;
               hold_left = '0;
            end
         endcase
      end
      word = '0;
      word.scl_release = scl_out;
      word.sda_release = sda_out;
      word.busy_res = (seq_phase != i2cbr_pkg::PH_IDLE);
      word.done_res = finished;
      word.failed = finished & bus_stuck;
      return word;
   endfunction

   // ---------------------------------------------------------------------------------
   // Stimulus queue. The initial block below fills it before reset is released; the
   // driver drains it. A pause entry holds the sender until every word sent has come
   // back and a few more cycles have passed, and every register write sits behind one.
   // ---------------------------------------------------------------------------------

   stim_type stim_q[$];

   task automatic add_tick(logic go, logic sda, logic scl);
      stim_type s;
      s.kind = STIM_TICK;
      s.go = go;
      s.sda = sda;
      s.scl = scl;
      s.index = i2cbr_pkg::CSR_ABORT_TICKS;
      s.data = '0;
      stim_q.push_back(s);
   endtask

   task automatic add_pause();
      stim_type s;
      s.kind = STIM_DRAIN;
      s.go = 1'b0;
      s.sda = 1'b0;
      s.scl = 1'b0;
      s.index = i2cbr_pkg::CSR_ABORT_TICKS;
      s.data = '0;
      stim_q.push_back(s);
   endtask

   task automatic add_write(i2cbr_pkg::csr_index_type index, logic [31:0] data);
      stim_type s;
      add_pause();
      s.kind = STIM_CSR;
      s.go = 1'b0;
      s.sda = 1'b0;
      s.scl = 1'b0;
      s.index = index;
      s.data = data;
      stim_q.push_back(s);
   endtask

   // ---------------------------------------------------------------------------------
   // Cycle count and watchdog. The count opens a window in which neither side idles.
   // The watchdog ends the run if no handshake of any kind happens for too long.
   // ---------------------------------------------------------------------------------

   int unsigned cycle_count = 0;
   int unsigned quiet_cycles = 0;
   logic        steady;

   assign steady = (cycle_count >= STEADY_FROM) && (cycle_count < STEADY_TO);

   always @(posedge clock) begin
      if (reset) begin
         cycle_count <= 0;
         quiet_cycles <= 0;
      end else begin
         cycle_count <= cycle_count + 1;
         if ((req_tvalid && req_tready) || (rsp_tvalid && rsp_tready) ||
             (csr_valid && csr_ready)) begin
            quiet_cycles <= 0;
         end else if (quiet_cycles == WATCHDOG_LIMIT) begin
            $display("FAIL");
            $finish;
         end else begin
            quiet_cycles <= quiet_cycles + 1;
         end
      end
   end

   // ---------------------------------------------------------------------------------
   // Driver. Input words and register writes are driven at the rising edge and held
   // until taken. The driver tracks how many words are still inside the block from the
   // handshakes themselves, so it never has to look at the checker's queue.
   // ---------------------------------------------------------------------------------

   int unsigned words_out;
   int unsigned settle;
   logic        stim_done = 1'b0;

   always @(posedge clock) begin
      stim_type nxt;
      logic     req_next;
      logic     csr_next;
      if (reset) begin
         req_tvalid <= 1'b0;
         req_tdata <= '0;
         csr_valid <= 1'b0;
         csr_index <= i2cbr_pkg::CSR_ABORT_TICKS;
         csr_data <= '0;
         stim_done <= 1'b0;
         words_out = 0;
         settle = 0;
      end else begin
         if (req_tvalid && req_tready)
            words_out++;
         if (rsp_tvalid && rsp_tready)
            words_out--;
         // A word that has not been taken yet stays on the bus unchanged.
         req_next = req_tvalid && !req_tready;
         csr_next = csr_valid && !csr_ready;
         if (!req_next && !csr_next) begin
            if (stim_q.size() == 0 || stim_q[0].kind == STIM_DRAIN) begin
               // Wait for every word to return, then let the block settle.
               if (words_out != 0) begin
                  settle = 0;
               end else if (settle < SETTLE_CYCLES) begin
                  settle++;
               end else if (stim_q.size() == 0) begin
                  stim_done <= 1'b1;
               end else begin
                  settle = 0;
                  stim_q.delete(0);
               end
            end else if (stim_q[0].kind == STIM_CSR) begin
               nxt = stim_q.pop_front();
               csr_next = 1'b1;
               csr_index <= nxt.index;
               csr_data <= nxt.data;
            end else if (steady || $urandom_range(99) >= IDLE_PCT) begin
               nxt = stim_q.pop_front();
               req_next = 1'b1;
               req_tdata <= {5'b0, nxt.scl, nxt.sda, nxt.go};
            end
         end
         req_tvalid <= req_next;
         csr_valid <= csr_next;
      end
   end

   // ---------------------------------------------------------------------------------
   // Monitor. It follows the register writes, steps the prediction for every accepted
   // input word and checks every accepted result word against the oldest prediction.
   // It also drives the result side's ready with random stalls.
   // ---------------------------------------------------------------------------------

   i2cbr_pkg::rsp_word_type line_state_q[$];
   int unsigned  mismatch_count = 0;
   int unsigned  words_checked = 0;

   always @(posedge clock) begin
      i2cbr_pkg::rsp_word_type want;
      i2cbr_pkg::rsp_word_type got;
      if (reset) begin
         rsp_tready <= 1'b0;
         line_state_q.delete();
         cfg_abort_len = i2cbr_pkg::ABORT_TICKS_RESET;
         cfg_half_len = i2cbr_pkg::HALF_TICKS_RESET;
         cfg_pulse_max = i2cbr_pkg::MAX_PULSES_RESET;
         cfg_start_reps = i2cbr_pkg::START_REPEATS_RESET;
         seq_phase = i2cbr_pkg::PH_IDLE;
         hold_left = '0;
         pulses_sent = '0;
         starts_sent = '0;
         scl_out = 1'b1;
         sda_out = 1'b1;
         bus_stuck = 1'b0;
      end else begin
         if (csr_valid && csr_ready) begin
            case (i2cbr_pkg::csr_index_type'(csr_index))
               i2cbr_pkg::CSR_ABORT_TICKS:   cfg_abort_len = csr_data[TICKS_WIDTH-1:0];
               i2cbr_pkg::CSR_HALF_TICKS:    cfg_half_len = csr_data[TICKS_WIDTH-1:0];
               i2cbr_pkg::CSR_MAX_PULSES:    cfg_pulse_max = csr_data[PULSES_WIDTH-1:0];
               i2cbr_pkg::CSR_START_REPEATS: cfg_start_reps = csr_data[REPEATS_WIDTH-1:0];
               default: ;
            endcase
         end
         if (req_tvalid && req_tready)
            line_state_q.push_back(bus_clear_tick(req_tdata[0], req_tdata[1], req_tdata[2]));
         if (rsp_tvalid && rsp_tready) begin
            got = i2cbr_pkg::rsp_word_type'(rsp_tdata);
            if (line_state_q.size() == 0) begin
               mismatch_count++;
               if (mismatch_count <= REPORT_LIMIT)
                  $display("result word %0d arrived with nothing outstanding: %b",
                           words_checked, rsp_tdata);
            end else begin
               want = line_state_q.pop_front();
               if (got.scl_release !== want.scl_release ||
                   got.sda_release !== want.sda_release ||
                   got.busy_res !== want.busy_res ||
                   got.done_res !== want.done_res ||
                   got.failed !== want.failed ||
                   got.pad !== want.pad) begin
                  mismatch_count++;
                  if (mismatch_count <= REPORT_LIMIT)
                     $display({"word %0d: expected scl=%b sda=%b busy=%b done=%b failed=%b ",
                               "pad=%b, got scl=%b sda=%b busy=%b done=%b failed=%b pad=%b"},
                              words_checked, want.scl_release, want.sda_release,
                              want.busy_res, want.done_res, want.failed, want.pad,
                              got.scl_release, got.sda_release, got.busy_res,
                              got.done_res, got.failed, got.pad);
               end
            end
            words_checked++;
         end
         rsp_tready <= steady || ($urandom_range(99) >= IDLE_PCT);
      end
   end

   // ---------------------------------------------------------------------------------
   // Stimulus and end of run.
   // ---------------------------------------------------------------------------------

   initial begin
      logic [TICKS_WIDTH-1:0]   abort_v;
      logic [TICKS_WIDTH-1:0]   half_v;
      logic [PULSES_WIDTH-1:0]  pulses_v;
      logic [REPEATS_WIDTH-1:0] reps_v;
      int unsigned              sda_low_pct;

      // Short timings so the directed words walk through whole runs: two pulses at
      // most and a single start sequence.
      add_write(i2cbr_pkg::CSR_ABORT_TICKS, 32'd2);
      add_write(i2cbr_pkg::CSR_HALF_TICKS, 32'd1);
      add_write(i2cbr_pkg::CSR_MAX_PULSES, 32'd2);
      add_write(i2cbr_pkg::CSR_START_REPEATS, 32'd1);

      // Every combination of the three input bits. The first go comes with SDA low,
      // so a recovery run starts and the remaining go requests land while busy.
      for (int i = 0; i < 8; i++)
         add_tick(i[0], i[1], i[2]);
      // SDA held low until the pulse limit is reached: the run ends as failed.
      for (int i = 0; i < 8; i++)
         add_tick(1'b0, 1'b0, 1'b1);
      // A fresh run with SDA free goes straight to the start sequences and stop,
      // with go held high across the done tick.
      for (int i = 0; i < 9; i++)
         add_tick(1'b1, 1'b1, 1'b1);

      // Random phases, each with its own register settings. The early phases pin the
      // corner settings: zero hold lengths, the pulse limit below and above its range,
      // no start sequences and the most of them.
      for (int p = 0; p < PHASES; p++) begin
         abort_v = TICKS_WIDTH'($urandom_range(4, 1));
         half_v = TICKS_WIDTH'($urandom_range(3, 1));
         pulses_v = PULSES_WIDTH'($urandom_range(16, 1));
         reps_v = REPEATS_WIDTH'($urandom_range(7, 0));
         case (p)
            0: begin
               abort_v = '0;
               half_v = '0;
               pulses_v = '0;
               reps_v = '0;
            end
            1: begin
               abort_v = 16'd1;
               half_v = 16'd1;
               pulses_v = 5'd31;
               reps_v = 3'd7;
            end
            2: begin
               pulses_v = i2cbr_pkg::MAX_PULSE_LIMIT;
               reps_v = 3'd7;
            end
            3: pulses_v = 5'd17;
            default: ;
         endcase
         // Upper data bits are random; only the register's own width counts.
         add_write(i2cbr_pkg::CSR_ABORT_TICKS, {16'($urandom), abort_v});
         add_write(i2cbr_pkg::CSR_HALF_TICKS, {16'($urandom), half_v});
         add_write(i2cbr_pkg::CSR_MAX_PULSES, {27'($urandom), pulses_v});
         add_write(i2cbr_pkg::CSR_START_REPEATS, {29'($urandom), reps_v});
         for (int b = 0; b < BURSTS; b++) begin
            // Each burst leans SDA toward stuck low, toward free, or neither, so both
            // failed and successful runs come up under every setting.
            case ($urandom_range(2))
               0:       sda_low_pct = 90;
               1:       sda_low_pct = 50;
               default: sda_low_pct = 10;
            endcase
            if (b == BURSTS / 2 && p % 3 == 0)
               add_pause();
            for (int i = 0; i < BURST_WORDS; i++)
               add_tick($urandom_range(99) < 25, $urandom_range(99) >= sda_low_pct,
                        $urandom_range(99) < 75);
         end
      end

      // Long hold lengths with no start sequences: one run that sits out the full
      // stop spacing twice. Go stays low afterwards so no second run begins.
      add_write(i2cbr_pkg::CSR_ABORT_TICKS, {16'($urandom), 16'(LONG_HOLD)});
      add_write(i2cbr_pkg::CSR_HALF_TICKS, {16'($urandom), 16'(LONG_HOLD)});
      add_write(i2cbr_pkg::CSR_START_REPEATS, {29'($urandom), 3'd0});
      add_tick(1'b1, 1'b1, 1'b1);
      for (int i = 0; i < 2 * LONG_HOLD + 8; i++)
         add_tick(1'b0, 1'($urandom), 1'($urandom));

      repeat (8) @(posedge clock);
      reset <= 1'b0;

      while (!stim_done)
         @(posedge clock);
      // Any prediction still waiting means a result word never came back.
      if (line_state_q.size() != 0)
         mismatch_count += line_state_q.size();
      if (mismatch_count == 0)
         $display("PASS");
      else
         $display("FAIL");
      $finish;
   end

endmodule
